>>> hdl/ddsp_pkg.sv
package ddsp_pkg;

	localparam int VALUE_W  = 64;
	localparam int COORD_W  = 12;
	localparam int WIDTH_W  = 6;
	localparam int DIGIT_W  = 4;
	localparam int SRCX_W   = 10;
	localparam int DESTX_W  = 13;
	// Largest row offset is 21 * 63 = 1323, which fits in 11 bits.
	localparam int OFF_W    = 11;
	localparam int BITCNT_W = 6;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd19;

	typedef struct packed {
		logic [COORD_W-1:0] anchor_x;
		logic [COORD_W-1:0] anchor_y;
		logic [WIDTH_W-1:0] digit_width;
	} ddsp_job_t;

endpackage

>>> hdl/ddsp_in_if.sv
interface ddsp_in_if import ddsp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [COORD_W-1:0]  anchor_x;
	logic [COORD_W-1:0]  anchor_y;

	modport source (output valid, value, anchor_x, anchor_y, input ready);
	modport sink (input valid, value, anchor_x, anchor_y, output ready);
endinterface

>>> hdl/ddsp_out_if.sv
interface ddsp_out_if import ddsp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [DIGIT_W-1:0]         digit_value;
	logic [SRCX_W-1:0]          source_x;
	logic signed [DESTX_W-1:0]  dest_x;
	logic [COORD_W-1:0]         dest_y;
	logic                       last_digit;

	modport source (output valid, digit_value, source_x, dest_x, dest_y, last_digit,
		input ready);
	modport sink (input valid, digit_value, source_x, dest_x, dest_y, last_digit,
		output ready);
endinterface

>>> hdl/ddsp_cfg_if.sv
interface ddsp_cfg_if import ddsp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WIDTH_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hdl/ddsp_conv.sv
module ddsp_conv import ddsp_pkg::*; #(
	parameter int DIGIT_COUNT = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [VALUE_W-1:0]        value,
	output logic                      busy,
	output logic                      done,
	output logic [4*DIGIT_COUNT-1:0]  bcd
);

	localparam int BCD_W = 4 * DIGIT_COUNT;

	logic                 busy_q;
	logic                 done_q;
	logic [BITCNT_W-1:0]  cnt_q;
	logic [VALUE_W-1:0]   val_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;
	logic                 last_bit;

	// Shift-add-3: every digit of five or more is corrected before the doubling shift.
	// A carry out of the top digit is dropped, which keeps the low digits only.
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign last_bit = (cnt_q == {BITCNT_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], val_q[VALUE_W-1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign bcd  = bcd_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("conversion started while busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished conversion");

endmodule

>>> hdl/ddsp_emit.sv
module ddsp_emit import ddsp_pkg::*; #(
	parameter int DIGIT_COUNT = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [4*DIGIT_COUNT-1:0]  bcd,
	input  ddsp_job_t                 job,
	output logic                      busy,
	ddsp_out_if.source                draw_out
);

	localparam int BCD_W = 4 * DIGIT_COUNT;
	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

	logic                 act_q;
	logic                 lead_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [OFF_W-1:0]     off_q;
	ddsp_job_t            job_q;

	logic                 ov_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic [SRCX_W-1:0]    srcx_q;
	logic [DESTX_W-1:0]   destx_q;
	logic [COORD_W-1:0]   desty_q;
	logic                 last_q;

	logic [DIGIT_W-1:0]   top_dig;
	logic                 is_last;
	logic                 skip;
	logic                 emit_go;

	assign top_dig = bcd_q[BCD_W-1 -: 4];
	assign is_last = (idx_q == LAST_IDX);
	// Leading zeros are stepped over without a transfer; the units digit never is.
	assign skip    = act_q && lead_q && (top_dig == '0) && !is_last;
	assign emit_go = act_q && !skip && (!ov_q || draw_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			lead_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				act_q  <= 1'b1;
				lead_q <= 1'b1;
			end else if (emit_go) begin
				lead_q <= 1'b0;
				if (is_last) begin
					act_q <= 1'b0;
				end
			end
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (draw_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= bcd;
			idx_q <= '0;
			off_q <= OFF_W'(DIGIT_COUNT + 1) * {{(OFF_W-WIDTH_W){1'b0}}, job.digit_width};
			job_q <= job;
		end else if (skip || emit_go) begin
			bcd_q <= bcd_q << 4;
			idx_q <= idx_q + 1'b1;
			off_q <= off_q - {{(OFF_W-WIDTH_W){1'b0}}, job_q.digit_width};
		end
		if (emit_go) begin
			digit_q <= top_dig;
			srcx_q  <= {{(SRCX_W-WIDTH_W){1'b0}}, job_q.digit_width}
				* {{(SRCX_W-DIGIT_W){1'b0}}, top_dig};
			destx_q <= {{(DESTX_W-COORD_W){1'b0}}, job_q.anchor_x}
				- {{(DESTX_W-OFF_W){1'b0}}, off_q};
			desty_q <= job_q.anchor_y;
			last_q  <= is_last;
		end
	end

	assign busy                 = act_q;
	assign draw_out.valid       = ov_q;
	assign draw_out.digit_value = digit_q;
	assign draw_out.source_x    = srcx_q;
	assign draw_out.dest_x      = destx_q;
	assign draw_out.dest_y      = desty_q;
	assign draw_out.last_digit  = last_q;

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !act_q)
		else $error("digit row loaded while a row is still being emitted");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && is_last |=> !act_q && ov_q && last_q)
		else $error("units digit did not end the row");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && lead_q && !is_last |-> top_dig != '0)
		else $error("leading zero emitted");

endmodule

>>> hdl/decimal_digit_sprite_placer_core.sv
// Channel   Modport  Payload                                            Transfer
// cfg       sink     data: digit_width (6)                              valid & ready
// num_in    sink     value (64), anchor_x (12), anchor_y (12)           valid & ready
// draw_out  source   digit_value, source_x, dest_x, dest_y, last_digit  valid & ready
//
// A number is converted one value bit per cycle through the BCD shifter and handed to the
// emitter, which steps over each leading zero and then sends each shown digit on draw_out;
// num_in is ready again once the converter and the emitter are both idle.
// A stall on draw_out holds the emitter; the next number is taken once the emitter is done.
// Reset clears the control flags and sets digit_width to 19; cfg is always ready.
module decimal_digit_sprite_placer_core import ddsp_pkg::*; #(
	parameter int DIGIT_COUNT = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	ddsp_cfg_if.sink    cfg,
	ddsp_in_if.sink     num_in,
	ddsp_out_if.source  draw_out
);

	logic [WIDTH_W-1:0]        dw_q;
	ddsp_job_t                 job_q;
	logic                      start;
	logic                      conv_busy;
	logic                      conv_done;
	logic                      emit_busy;
	logic [4*DIGIT_COUNT-1:0]  bcd;

	assign cfg.ready    = 1'b1;
	assign num_in.ready = !conv_busy && !conv_done && !emit_busy;
	assign start        = num_in.valid && num_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= WIDTH_RESET;
		end else if (cfg.valid) begin
			dw_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q.anchor_x    <= num_in.anchor_x;
			job_q.anchor_y    <= num_in.anchor_y;
			job_q.digit_width <= dw_q;
		end
	end

	ddsp_conv #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (num_in.value),
		.busy   (conv_busy),
		.done   (conv_done),
		.bcd    (bcd)
	);

	ddsp_emit #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (conv_done),
		.bcd      (bcd),
		.job      (job_q),
		.busy     (emit_busy),
		.draw_out (draw_out)
	);

endmodule
